// ===== hw/rtl/rlbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbd_pkg: shared types and constants
// Phase and terminal codes, result codes and the result record that moves
// from the front decoder through the result queue to the output stage.
// ----------------------------------------------------------------------------
package rlbd_pkg;

	// Header byte layout.
	localparam logic [7:0] LEN_MASK  = 8'h7F;
	localparam logic [7:0] FILL_FLAG = 8'h80;

	// Depth of the result queue between front and back.
	localparam int QDEPTH = 4;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_FILL    = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		TS_RUNNING = 2'd0,
		TS_DONE    = 2'd1,
		TS_ERROR   = 2'd2
	} term_t;

	typedef enum logic [1:0] {
		ST_WRITE = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [10:0] start_address;
		logic [7:0]  run_length;
		logic [7:0]  fill_value;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== hw/rtl/rlbd_front.sv =====
// ----------------------------------------------------------------------------
// rlbd_front: stream decoder
// Accepts coded bytes, tracks the run state and buffer position, and pushes
// one result record per producing byte into the result queue.
// ----------------------------------------------------------------------------
module rlbd_front #(
	parameter int BUFFER_BYTES = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_kind,
	input  logic [7:0]    in_byte,
	input  rlbd_pkg::qstat_t q_stat,
	output logic          push,
	output rlbd_pkg::res_t push_res
);
	import rlbd_pkg::*;

	localparam int PosW    = $clog2(BUFFER_BYTES + 1);
	localparam int SumW    = $clog2(BUFFER_BYTES + 129);
	localparam int Quarter = BUFFER_BYTES / 4;

	phase_t          phase_q, phase_d;
	term_t           term_q, term_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic [7:0]      rem_q, rem_d;

	logic       take;
	logic       buf_full;
	logic       over;
	logic       end_ok;
	logic [7:0] hdr_len;

	assign in_ready = !q_stat.full;
	assign take     = in_valid && in_ready && (term_q == TS_RUNNING);

	assign hdr_len  = (in_byte & LEN_MASK) + 8'd1;
	assign buf_full = (SumW'(pos_q) >= SumW'(BUFFER_BYTES));
	assign over     = (SumW'(pos_q) + SumW'(hdr_len)) > SumW'(BUFFER_BYTES);
	assign end_ok   = (phase_q == PH_HEADER) &&
		((pos_q == PosW'(BUFFER_BYTES)) || (pos_q == PosW'(Quarter)));

	// Next state.
	always_comb begin
		phase_d = phase_q;
		term_d  = term_q;
		pos_d   = pos_q;
		rem_d   = rem_q;
		if (take) begin
			if (in_kind) begin
				term_d = end_ok ? TS_DONE : TS_ERROR;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (!buf_full) begin
							if (over) begin
								term_d = TS_ERROR;
							end else begin
								rem_d   = hdr_len;
								phase_d = ((in_byte & FILL_FLAG) != 8'd0) ? PH_FILL : PH_LITERAL;
							end
						end
					end
					PH_FILL: begin
						pos_d   = pos_q + PosW'(rem_q);
						rem_d   = 8'd0;
						phase_d = PH_HEADER;
					end
					PH_LITERAL: begin
						pos_d = pos_q + PosW'(1);
						rem_d = rem_q - 8'd1;
						if (rem_q == 8'd1) begin
							phase_d = PH_HEADER;
						end
					end
					default: phase_d = PH_HEADER;
				endcase
			end
		end
	end

	// Result record.
	always_comb begin
		push     = 1'b0;
		push_res = '{status: ST_WRITE, start_address: 11'd0, run_length: 8'd0,
			fill_value: 8'd0};
		if (take) begin
			if (in_kind) begin
				push            = 1'b1;
				push_res.status = end_ok ? ST_DONE : ST_ERROR;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (!buf_full && over) begin
							push            = 1'b1;
							push_res.status = ST_ERROR;
						end
					end
					PH_FILL: begin
						push                   = 1'b1;
						push_res.start_address = 11'(pos_q);
						push_res.run_length    = rem_q;
						push_res.fill_value    = in_byte;
					end
					PH_LITERAL: begin
						push                   = 1'b1;
						push_res.start_address = 11'(pos_q);
						push_res.run_length    = 8'd1;
						push_res.fill_value    = in_byte;
					end
					default: push = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			term_q  <= TS_RUNNING;
			pos_q   <= '0;
			rem_q   <= 8'd0;
		end else begin
			phase_q <= phase_d;
			term_q  <= term_d;
			pos_q   <= pos_d;
			rem_q   <= rem_d;
		end
	end

endmodule

// ===== hw/rtl/rlbd_queue.sv =====
// ----------------------------------------------------------------------------
// rlbd_queue: result queue
// Small first-in first-out store of result records between the decoder and
// the output stage.
// ----------------------------------------------------------------------------
module rlbd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rlbd_pkg::res_t   push_res,
	input  logic             pop,
	output rlbd_pkg::res_t   head,
	output rlbd_pkg::qstat_t stat
);
	import rlbd_pkg::*;

	localparam int QAW = $clog2(QDEPTH);

	res_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign stat.full  = (count_q == (QAW + 1)'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW + 1)'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/rlbd_back.sv =====
// ----------------------------------------------------------------------------
// rlbd_back: output stage
// Takes result records from the queue into an output register and presents
// them on the result stream.
// ----------------------------------------------------------------------------
module rlbd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rlbd_pkg::qstat_t q_stat,
	input  rlbd_pkg::res_t   head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output rlbd_pkg::res_t   out_res
);
	import rlbd_pkg::*;

	logic valid_q;
	res_t res_q;

	assign pop       = !q_stat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/run_length_buffer_decoder_top.sv =====
// ----------------------------------------------------------------------------
// run_length_buffer_decoder_top: run-length coded stream to buffer writes
// Path: a result goes through a queue entry and then the output register before
// it leaves on the master side. Throughput: one byte per cycle while the queue
// has room, set by the state update of the front decoder; a four-entry queue
// lets the decoder run on while results wait.
// Reset: arst_n clears the run state, position, sticky status and queue at once.
// ----------------------------------------------------------------------------
//
// The block splits into three parts. The front decoder takes one coded byte
// per transaction, keeps the phase (header, fill value or literal bytes), the
// buffer position, the count of literal bytes still due and the sticky
// done/error status, and builds at most one result record per byte. Records
// go into a short queue. The back stage moves the queue head into an output
// register that drives the master side, so a stalled consumer only fills the
// queue; the slave side is held off only when the queue is full.
//
// A fill run comes out as one write record with its full length; every
// literal byte comes out as a write of length one. An overrunning header gives
// an error record; other headers and data bytes after the buffer is full give
// none. After done or error, every further transaction is taken and dropped.
module run_length_buffer_decoder_top #(
	parameter int BUFFER_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,   // [0] kind: 1 = end of stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [10:0] start_address, [18:11] run_length,
	                                    // [26:19] fill_value, [31:27] zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import rlbd_pkg::*;

	// Wiring between the front decoder, the queue and the output stage.
	logic   push;
	res_t   push_res;
	logic   pop;
	res_t   head;
	qstat_t q_stat;
	res_t   out_res;

	rlbd_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser[0]),
		.in_byte  (s_axis_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_res (push_res)
	);

	rlbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	rlbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the record: status travels in tuser, the write fields in tdata.
	assign m_axis_tuser = out_res.status;
	assign m_axis_tdata = {5'd0, out_res.fill_value, out_res.run_length,
		out_res.start_address};

endmodule
